### rtl/core/csfpb_pkg.sv
// Shared types, constants and helpers for the fiber pointer builder.
// No dependencies; every other file in rtl/core imports this package.
package csfpb_pkg;

    localparam int MAX_MODES_DEFAULT  = 4;
    localparam int COORD_BITS_DEFAULT = 32;

    // Fixed widths of the transaction fields
    localparam int FIELD_W    = 32;
    localparam int CNT_W      = 32;
    localparam int LEVEL_BITS = 2;
    localparam int MODE_BITS  = 2;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int MODES_W    = 3;
    localparam int ORDER_W    = 8;

    localparam logic REG_MODES_IN_USE = 1'b0;
    localparam logic REG_MODE_ORDER   = 1'b1;

    localparam logic [MODES_W-1:0] MODES_RESET = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd228;

    localparam int QUEUE_DEPTH = 2;

    // Coordinate field selects
    localparam logic [MODE_BITS-1:0] MODE_0 = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_1 = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_2 = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_3 = 2'd3;

    // Classification of one nonzero, handed from front to back
    typedef struct packed {
        logic [LEVEL_BITS-1:0] first_lvl;
        logic [LEVEL_BITS-1:0] leaf_lvl;
        logic                  last;
    } class_t;

    localparam int CLASS_W = $bits(class_t);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

### rtl/core/csfpb_front.sv
// Front end: orders the coordinates of each nonzero, compares with the previous
// tuple and classifies the first opened level. Depends on csfpb_pkg.
module csfpb_front #(
    parameter int MAX_MODES  = csfpb_pkg::MAX_MODES_DEFAULT,
    parameter int COORD_BITS = csfpb_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                q_full,
    input  logic [csfpb_pkg::FIELD_W-1:0]       coord_0,
    input  logic [csfpb_pkg::FIELD_W-1:0]       coord_1,
    input  logic [csfpb_pkg::FIELD_W-1:0]       coord_2,
    input  logic [csfpb_pkg::FIELD_W-1:0]       coord_3,
    input  logic                                is_last,
    input  logic [csfpb_pkg::MODES_W-1:0]       modes_in_use,
    input  logic [csfpb_pkg::ORDER_W-1:0]       mode_order,
    output logic                                push,
    output logic [(MAX_MODES-1)*COORD_BITS-1:0] push_tuple,
    output csfpb_pkg::class_t                   push_class
);
    import csfpb_pkg::*;

    localparam int SLOTS = MAX_MODES - 1;
    localparam logic [MODES_W-1:0] N_MAX = MODES_W'(MAX_MODES);
    localparam logic [MODES_W-1:0] N_MIN = MODES_W'(2);

    logic [COORD_BITS-1:0] prev_reg  [SLOTS];
    logic [COORD_BITS-1:0] prev_next [SLOTS];
    logic [COORD_BITS-1:0] cur       [SLOTS];
    logic                  first_pending_reg;
    logic                  first_pending_next;
    logic [MODES_W-1:0]    n_eff;
    logic [LEVEL_BITS-1:0] last_slot;
    logic [LEVEL_BITS-1:0] first_lvl;
    logic [MODE_BITS-1:0]  sel_mode;

    assign push = in_valid && !q_full;

    always_comb
    begin
        if (modes_in_use < N_MIN)
            n_eff = N_MIN;
        else if (modes_in_use > N_MAX)
            n_eff = N_MAX;
        else
            n_eff = modes_in_use;
        last_slot = LEVEL_BITS'(n_eff - MODES_W'(1));
    end

    // Order the level coordinates; the leaf slot is never compared
    always_comb
    begin
        sel_mode = MODE_0;
        for (int j = 0; j < SLOTS; j++)
        begin
            sel_mode = mode_order[MODE_BITS*j +: MODE_BITS];
            unique case (sel_mode)
                MODE_0: cur[j] = coord_0[COORD_BITS-1:0];
                MODE_1: cur[j] = coord_1[COORD_BITS-1:0];
                MODE_2: cur[j] = coord_2[COORD_BITS-1:0];
                MODE_3: cur[j] = coord_3[COORD_BITS-1:0];
                default: cur[j] = coord_0[COORD_BITS-1:0];
            endcase
            push_tuple[j*COORD_BITS +: COORD_BITS] = cur[j];
        end
    end

    // First differing slot; scan downward so the lowest wins
    always_comb
    begin
        first_lvl = last_slot;
        for (int j = SLOTS - 1; j >= 0; j--)
        begin
            if ((LEVEL_BITS'(j) < last_slot) && (cur[j] != prev_reg[j]))
                first_lvl = LEVEL_BITS'(j);
        end
        if (first_pending_reg)
            first_lvl = '0;
    end

    always_comb
    begin
        push_class.first_lvl = first_lvl;
        push_class.leaf_lvl  = LEVEL_BITS'(n_eff - N_MIN);
        push_class.last      = is_last;
    end

    always_comb
    begin
        prev_next          = prev_reg;
        first_pending_next = first_pending_reg;
        if (push)
        begin
            prev_next          = cur;
            first_pending_next = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b1;
            for (int j = 0; j < SLOTS; j++)
            begin
                prev_reg[j] <= '0;
            end
        end
        else
        begin
            first_pending_reg <= first_pending_next;
            prev_reg          <= prev_next;
        end
    end

    a_first_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ({1'b0, push_class.first_lvl} <= ({1'b0, push_class.leaf_lvl} + 3'd1)))
        else $error("front: first opened level beyond leaf-parent");

endmodule

### rtl/core/csfpb_queue.sv
// Short register queue that decouples the front end from the record sequencer.
// Depends on csfpb_pkg for its depth.
module csfpb_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);
    import csfpb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_QW'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_QW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (full && push) |-> pop)
        else $error("queue: push into full queue");

endmodule

### rtl/core/csfpb_back.sv
// Back end: walks the opened levels of each queued nonzero, keeps the fiber
// counters and nonzero position, and drives the output register. Depends on csfpb_pkg.
module csfpb_back #(
    parameter int MAX_MODES  = csfpb_pkg::MAX_MODES_DEFAULT,
    parameter int COORD_BITS = csfpb_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [(MAX_MODES-1)*COORD_BITS-1:0] q_tuple,
    input  csfpb_pkg::class_t                   q_class,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [csfpb_pkg::LEVEL_BITS-1:0]    level,
    output logic [csfpb_pkg::FIELD_W-1:0]       fiber_id,
    output logic [csfpb_pkg::FIELD_W-1:0]       child_start,
    output logic [csfpb_pkg::FIELD_W-1:0]       index_value,
    output logic                                is_end_record,
    output logic                                last_of_run
);
    import csfpb_pkg::*;

    localparam int FC_DEPTH = MAX_MODES - 1;

    typedef enum logic {PH_REC, PH_END} phase_t;

    phase_t                phase_reg, phase_next;
    logic                  started_reg, started_next;
    logic [LEVEL_BITS-1:0] lvl_reg, lvl_next;
    logic [CNT_W-1:0]      fc_reg [FC_DEPTH];
    logic [CNT_W-1:0]      fc_next [FC_DEPTH];
    logic [CNT_W-1:0]      nzpos_reg, nzpos_next;

    logic                  out_valid_reg, out_valid_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [FIELD_W-1:0]    fiber_id_reg, fiber_id_next;
    logic [FIELD_W-1:0]    child_start_reg, child_start_next;
    logic [FIELD_W-1:0]    index_value_reg, index_value_next;
    logic                  end_reg, end_next;
    logic                  last_reg, last_next;

    logic [LEVEL_BITS-1:0] cur_lvl;
    logic [LEVEL_BITS-1:0] sel_lvl;
    logic [LEVEL_BITS-1:0] sel_lvl_inc;
    logic [CNT_W-1:0]      fid_sel;
    logic [CNT_W-1:0]      child_sel;
    logic [CNT_W-1:0]      cs_sel;
    logic [COORD_BITS-1:0] idx_sel;
    logic                  out_free;

    assign out_valid     = out_valid_reg;
    assign level         = level_reg;
    assign fiber_id      = fiber_id_reg;
    assign child_start   = child_start_reg;
    assign index_value   = index_value_reg;
    assign is_end_record = end_reg;
    assign last_of_run   = last_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // Level under work and the counters it reads
    always_comb
    begin
        cur_lvl     = started_reg ? lvl_reg : q_class.first_lvl;
        sel_lvl     = (phase_reg == PH_END) ? lvl_reg : cur_lvl;
        sel_lvl_inc = sel_lvl + LEVEL_BITS'(1);
        fid_sel     = '0;
        child_sel   = '0;
        idx_sel     = '0;
        for (int i = 0; i < FC_DEPTH; i++)
        begin
            if (LEVEL_BITS'(i) == sel_lvl)
            begin
                fid_sel = fc_reg[i];
                idx_sel = q_tuple[i*COORD_BITS +: COORD_BITS];
            end
            if (LEVEL_BITS'(i) == sel_lvl_inc)
                child_sel = fc_reg[i];
        end
        cs_sel = (sel_lvl == q_class.leaf_lvl) ? nzpos_reg : child_sel;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        started_next     = started_reg;
        lvl_next         = lvl_reg;
        fc_next          = fc_reg;
        nzpos_next       = nzpos_reg;
        out_valid_next   = out_valid_reg && out_stall;
        level_next       = level_reg;
        fiber_id_next    = fiber_id_reg;
        child_start_next = child_start_reg;
        index_value_next = index_value_reg;
        end_next         = end_reg;
        last_next        = last_reg;
        pop              = 1'b0;

        if (q_valid)
        begin
            unique case (phase_reg)
                PH_REC:
                begin
                    if (cur_lvl > q_class.leaf_lvl)
                    begin
                        // identical prefix: no record; advance position, then pop or start end records
                        nzpos_next = sat_inc(nzpos_reg);
                        if (q_class.last)
                        begin
                            phase_next   = PH_END;
                            lvl_next     = '0;
                            started_next = 1'b1;
                        end
                        else
                        begin
                            pop          = 1'b1;
                            started_next = 1'b0;
                        end
                    end
                    else if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        level_next       = cur_lvl;
                        fiber_id_next    = fid_sel;
                        child_start_next = cs_sel;
                        index_value_next = FIELD_W'(idx_sel);
                        end_next         = 1'b0;
                        last_next        = (cur_lvl == q_class.leaf_lvl) && !q_class.last;
                        for (int i = 0; i < FC_DEPTH; i++)
                        begin
                            if (LEVEL_BITS'(i) == cur_lvl)
                                fc_next[i] = sat_inc(fc_reg[i]);
                        end
                        if (cur_lvl == q_class.leaf_lvl)
                        begin
                            nzpos_next = sat_inc(nzpos_reg);
                            if (q_class.last)
                            begin
                                phase_next   = PH_END;
                                lvl_next     = '0;
                                started_next = 1'b1;
                            end
                            else
                            begin
                                pop          = 1'b1;
                                started_next = 1'b0;
                            end
                        end
                        else
                        begin
                            lvl_next     = cur_lvl + LEVEL_BITS'(1);
                            started_next = 1'b1;
                        end
                    end
                end
                PH_END:
                begin
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        level_next       = lvl_reg;
                        fiber_id_next    = fid_sel;
                        child_start_next = cs_sel;
                        index_value_next = '0;
                        end_next         = 1'b1;
                        last_next        = (lvl_reg == q_class.leaf_lvl);
                        if (lvl_reg == q_class.leaf_lvl)
                        begin
                            // pass closed: drop all counters
                            for (int i = 0; i < FC_DEPTH; i++)
                            begin
                                fc_next[i] = '0;
                            end
                            nzpos_next   = '0;
                            pop          = 1'b1;
                            phase_next   = PH_REC;
                            started_next = 1'b0;
                        end
                        else
                        begin
                            lvl_next = lvl_reg + LEVEL_BITS'(1);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_REC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_REC;
            started_reg   <= 1'b0;
            lvl_reg       <= '0;
            nzpos_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FC_DEPTH; i++)
            begin
                fc_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            lvl_reg       <= lvl_next;
            nzpos_reg     <= nzpos_next;
            out_valid_reg <= out_valid_next;
            fc_reg        <= fc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg       <= level_next;
        fiber_id_reg    <= fiber_id_next;
        child_start_reg <= child_start_next;
        index_value_reg <= index_value_next;
        end_reg         <= end_next;
        last_reg        <= last_next;
    end

    a_end_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_END) |-> (q_valid && q_class.last))
        else $error("back: end records without a last nonzero at queue head");

    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> q_valid)
        else $error("back: queue head lost while its levels are in progress");

    a_pass_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (phase_reg == PH_END)) |=> (nzpos_reg == '0))
        else $error("back: position not cleared after end of pass");

endmodule

### rtl/core/csf_fiber_pointer_builder_core.sv
// Top level of the fiber pointer builder: configuration registers, front end,
// queue and record sequencer. Depends on csfpb_pkg, csfpb_front, csfpb_queue, csfpb_back.
//
// Sorted nonzeros enter one transaction per cycle while the two-entry queue
// has room; the front end compares each ordered tuple with the previous one
// in the cycle it is accepted. The record sequencer then issues one record
// per level a nonzero opens (from the first differing level down to the
// leaf-parent), none for a nonzero that opens no level, and one end record
// per level after a nonzero marked last. Records leave through a single
// output register at up to one per cycle while out_stall is low; the sequencer
// takes a new nonzero only once it is done with the current one. Counters
// saturate at all ones; after the last end record the counters, nonzero
// position and phase return to their reset values. Configuration is read back
// over the register port at byte address 0 (modes_in_use) and 4 (mode_order).
module csf_fiber_pointer_builder_core #(
    parameter int MAX_MODES  = csfpb_pkg::MAX_MODES_DEFAULT,
    parameter int COORD_BITS = csfpb_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [csfpb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [csfpb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [csfpb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [csfpb_pkg::FIELD_W-1:0]        coord_0,
    input  logic [csfpb_pkg::FIELD_W-1:0]        coord_1,
    input  logic [csfpb_pkg::FIELD_W-1:0]        coord_2,
    input  logic [csfpb_pkg::FIELD_W-1:0]        coord_3,
    input  logic                                 is_last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [csfpb_pkg::LEVEL_BITS-1:0]     level,
    output logic [csfpb_pkg::FIELD_W-1:0]        fiber_id,
    output logic [csfpb_pkg::FIELD_W-1:0]        child_start,
    output logic [csfpb_pkg::FIELD_W-1:0]        index_value,
    output logic                                 is_end_record,
    output logic                                 last_of_run
);
    import csfpb_pkg::*;

    localparam int TUPLE_W = (MAX_MODES - 1) * COORD_BITS;
    localparam int ENTRY_W = TUPLE_W + CLASS_W;

    logic [MODES_W-1:0] modes_reg;
    logic [ORDER_W-1:0] order_reg;
    logic               cfg_write;
    logic               reg_sel;

    logic               push;
    logic               q_full;
    logic               pop;
    logic               q_valid;
    logic [TUPLE_W-1:0] push_tuple;
    class_t             push_class;
    logic [ENTRY_W-1:0] q_head;
    class_t             head_class;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_MODES_IN_USE: prdata = APB_DATA_W'(modes_reg);
            REG_MODE_ORDER:   prdata = APB_DATA_W'(order_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg <= MODES_RESET;
            order_reg <= ORDER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_MODES_IN_USE: modes_reg <= pwdata[MODES_W-1:0];
                REG_MODE_ORDER:   order_reg <= pwdata[ORDER_W-1:0];
                default:          modes_reg <= modes_reg;
            endcase
        end
    end

    assign in_stall = q_full;

    csfpb_front #(
        .MAX_MODES  (MAX_MODES),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .q_full       (q_full),
        .coord_0      (coord_0),
        .coord_1      (coord_1),
        .coord_2      (coord_2),
        .coord_3      (coord_3),
        .is_last      (is_last),
        .modes_in_use (modes_reg),
        .mode_order   (order_reg),
        .push         (push),
        .push_tuple   (push_tuple),
        .push_class   (push_class)
    );

    csfpb_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_tuple, push_class}),
        .full       (q_full),
        .pop        (pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign head_class = class_t'(q_head[CLASS_W-1:0]);

    csfpb_back #(
        .MAX_MODES  (MAX_MODES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_tuple       (q_head[ENTRY_W-1:CLASS_W]),
        .q_class       (head_class),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .fiber_id      (fiber_id),
        .child_start   (child_start),
        .index_value   (index_value),
        .is_end_record (is_end_record),
        .last_of_run   (last_of_run)
    );

endmodule
